FILE: rtl/hel_pkg.sv
// Package for the hysteresis edge link core: sizes, class codes and register indexes.
// No dependencies; used by rtl/hysteresis_edge_link_core.sv and sim/tb_top.sv.

package hel_pkg;

    // Largest frame the line store holds
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);

    // Field widths
    localparam int MAG_W   = 16;
    localparam int SIZE_W  = 11;
    localparam int COORD_W = 10;
    localparam int THR_W   = 16;

    // Stream and configuration port widths
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Pixel class codes
    typedef logic [1:0] class_t;
    localparam class_t CLS_NONE   = 2'd0;
    localparam class_t CLS_WEAK   = 2'd1;
    localparam class_t CLS_STRONG = 2'd2;

    // Line store word: class of the row two above, then of the row one above
    localparam int LINE_W = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd3;

    // Register reset values
    localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH    = 11'd640;
    localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT   = 11'd480;
    localparam logic [THR_W-1:0]  RST_HIGH_THRESHOLD = 16'd20000;
    localparam logic [THR_W-1:0]  RST_LOW_THRESHOLD  = 16'd8000;

    localparam logic [SIZE_W-1:0] MIN_SIZE = 11'd3;
    localparam logic [SIZE_W-1:0] MAX_W_SZ = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H_SZ = SIZE_W'(MAX_HEIGHT);

    // Clamp a size register to the supported range
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] res;
        if (v < MIN_SIZE)
            res = MIN_SIZE;
        else if (v > hi)
            res = hi;
        else
            res = v;
        return res;
    endfunction

endpackage

FILE: rtl/hel_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.

module hel_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read; read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/hysteresis_edge_link_core.sv
// Hysteresis edge linking over a 3x3 window of pixel classes, one pixel per cycle while the output drains.
// A result passes from stage one into the output register before it is shown on m_tvalid.
// Throughput: one item per cycle while the output drains; the line store read issued on acceptance
// sets the two-stage depth, and a stalled output holds both stages.
// Reset clears counters, window, valid flags and loads the register defaults; the line
// store is not cleared and is fully written by the first two rows of a frame.
// Depends on rtl/hel_pkg.sv and rtl/hel_ram.sv.

module hysteresis_edge_link_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input pixels
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hel_pkg::S_DATA_W-1:0]  s_tdata,   // [15:0] magnitude
    // Results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hel_pkg::M_DATA_W-1:0]  m_tdata,   // [0] edge_res, [10:1] col,
                                                     // [20:11] row, [23:21] zero
    output logic                          m_tlast,   // frame_last
    // Configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hel_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hel_pkg::CFG_DAT_W-1:0] cfg_data
);

    import hel_pkg::*;

    // Configuration registers
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [THR_W-1:0]  high_thr_reg;
    logic [THR_W-1:0]  low_thr_reg;

    // Position counters
    logic [COORD_W-1:0] col_cnt_reg, col_cnt_next;
    logic [COORD_W-1:0] row_cnt_reg, row_cnt_next;

    // Stage one: item waiting for its line store data
    logic               v1_reg;
    logic [COORD_W-1:0] c1_reg;
    logic [COORD_W-1:0] r1_reg;
    class_t             k1_reg;
    logic               last1_reg;
    logic               emit1_reg;

    // Two older columns of the window, per row (index 0 older)
    class_t win_reg [3][2];

    // Output register
    logic               o_valid_reg;
    logic               o_edge_reg;
    logic [COORD_W-1:0] o_col_reg;
    logic [COORD_W-1:0] o_row_reg;
    logic               o_last_reg;

    // Stage zero signals
    logic [SIZE_W-1:0]  w_eff, h_eff;
    logic               accept, adv1;
    logic               wrap;
    logic [SIZE_W-1:0]  c0, r0, r_inc, c_plus, r_plus;
    class_t             k0;
    logic               last0, emit0;
    logic [MAG_W-1:0]   mag;

    // Stage one signals
    logic [LINE_W-1:0]  ram_rdata;
    class_t             up, mid, centre;
    logic               any_strong, edge1;

    assign cfg_ready = 1'b1;

    // Write configuration registers; unknown indexes cannot occur at this width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= RST_IMAGE_WIDTH;
            height_reg   <= RST_IMAGE_HEIGHT;
            high_thr_reg <= RST_HIGH_THRESHOLD;
            low_thr_reg  <= RST_LOW_THRESHOLD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:    width_reg    <= cfg_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:   height_reg   <= cfg_data[SIZE_W-1:0];
                REG_HIGH_THRESHOLD: high_thr_reg <= cfg_data[THR_W-1:0];
                REG_LOW_THRESHOLD:  low_thr_reg  <= cfg_data[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    assign w_eff = clamp_size(width_reg, MAX_W_SZ);
    assign h_eff = clamp_size(height_reg, MAX_H_SZ);

    // Handshake: stage one moves on when the output register is free or being drained
    assign adv1     = v1_reg && (!o_valid_reg || m_tready);
    assign s_tready = !v1_reg || adv1;
    assign accept   = s_tvalid && s_tready;

    // Fold the position, class the pixel, work out the next position
    always_comb
    begin
        mag   = s_tdata[MAG_W-1:0];
        wrap  = {1'b0, col_cnt_reg} >= w_eff;
        c0    = wrap ? '0 : {1'b0, col_cnt_reg};
        r_inc = {1'b0, row_cnt_reg} + (wrap ? SIZE_W'(1) : SIZE_W'(0));
        r0    = (r_inc >= h_eff) ? '0 : r_inc;

        if (mag >= high_thr_reg)
            k0 = CLS_STRONG;
        else if (mag >= low_thr_reg)
            k0 = CLS_WEAK;
        else
            k0 = CLS_NONE;

        last0 = (c0 == w_eff - SIZE_W'(1)) && (r0 == h_eff - SIZE_W'(1));
        emit0 = (c0 >= SIZE_W'(2)) && (r0 >= SIZE_W'(2));

        c_plus = c0 + SIZE_W'(1);
        r_plus = r0 + SIZE_W'(1);
        if (c_plus >= w_eff)
        begin
            col_cnt_next = '0;
            row_cnt_next = (r_plus >= h_eff) ? '0 : r_plus[COORD_W-1:0];
        end
        else
        begin
            col_cnt_next = c_plus[COORD_W-1:0];
            row_cnt_next = r0[COORD_W-1:0];
        end
    end

    // Advance counters and load stage one on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            v1_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
                v1_reg      <= 1'b1;
            end
            else if (adv1)
            begin
                v1_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            c1_reg    <= c0[COORD_W-1:0];
            r1_reg    <= r0[COORD_W-1:0];
            k1_reg    <= k0;
            last1_reg <= last0;
            emit1_reg <= emit0;
        end
    end

    // Line store: read on acceptance, rewrite the same column when stage one moves on
    hel_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (adv1),
        .waddr (c1_reg[ADDR_W-1:0]),
        .wdata ({mid, k1_reg}),
        .re    (accept),
        .raddr (c0[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Test the centre against its eight neighbours in the shifted window
    always_comb
    begin
        up     = ram_rdata[3:2];
        mid    = ram_rdata[1:0];
        centre = win_reg[1][1];
        any_strong = (win_reg[0][0] == CLS_STRONG) || (win_reg[0][1] == CLS_STRONG)
                  || (up == CLS_STRONG)            || (win_reg[1][0] == CLS_STRONG)
                  || (mid == CLS_STRONG)           || (win_reg[2][0] == CLS_STRONG)
                  || (win_reg[2][1] == CLS_STRONG) || (k1_reg == CLS_STRONG);
        edge1 = (centre == CLS_STRONG) || ((centre == CLS_WEAK) && any_strong);
    end

    // Shift the window by one column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= CLS_NONE;
                win_reg[i][1] <= CLS_NONE;
            end
        end
        else if (adv1)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
            end
            win_reg[0][1] <= up;
            win_reg[1][1] <= mid;
            win_reg[2][1] <= k1_reg;
        end
    end

    // Hold the result until taken; load interior pixels only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (adv1 && emit1_reg)
        begin
            o_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && emit1_reg)
        begin
            o_edge_reg <= edge1;
            o_col_reg  <= c1_reg - COORD_W'(1);
            o_row_reg  <= r1_reg - COORD_W'(1);
            o_last_reg <= last1_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {3'b000, o_row_reg, o_col_reg, o_edge_reg};
    assign m_tlast  = o_last_reg;

    // Emitted pixels are never on the top or left border
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (o_col_reg != '0) && (o_row_reg != '0))
        else $error("border pixel emitted");

    // The last item of a frame sits at the lower-right interior corner
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |->
            ({1'b0, o_col_reg} == w_eff - SIZE_W'(2))
            && ({1'b0, o_row_reg} == h_eff - SIZE_W'(2)))
        else $error("frame_last away from the last interior pixel");

    // A line store write never hits the column being read in the same cycle
    a_ram_hazard: assert property (@(posedge clk) disable iff (!rst_n)
        (adv1 && accept) |-> (c1_reg[ADDR_W-1:0] != c0[ADDR_W-1:0]))
        else $error("line store read and write collide");

    // Input is only held off while a result waits behind a full stage one
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (v1_reg && o_valid_reg && !m_tready))
        else $error("input stalled without back-pressure");

endmodule

FILE: sim/tb_top.sv
// Testbench for hysteresis_edge_link_core: a directed table, then random frames under
// several register settings and idle patterns, checked against an in-bench predictor.
// Depends on rtl/hel_pkg.sv and rtl/hysteresis_edge_link_core.sv.
`timescale 1ns / 100ps

module tb_top;
    import hel_pkg::*;

    localparam int  HALF_PERIOD   = 5;
    localparam int  RESET_CYCLES  = 9;
    localparam int  DRAIN_CYCLES  = 6;
    localparam int  PHASES        = 12;
    localparam int  PHASE_ITEMS   = 50;
    localparam int  MAX_REPORTS   = 200;
    localparam int  DIR_ROWS      = 27;
    localparam real LIMIT_NS      = 5.0e6;

    typedef struct packed {
        logic               is_edge;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               frame_last;
    } edge_item_t;

    typedef enum logic { ROW_PIX, ROW_REG } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DAT_W-1:0]   data;    // magnitude for a pixel row
        logic                   typed;   // want holds the expected result
        edge_item_t             want;
    } dir_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    // Predictor copy of the registers
    logic [SIZE_W-1:0] width_reg  = RST_IMAGE_WIDTH;
    logic [SIZE_W-1:0] height_reg = RST_IMAGE_HEIGHT;
    logic [THR_W-1:0]  thr_high   = RST_HIGH_THRESHOLD;
    logic [THR_W-1:0]  thr_low    = RST_LOW_THRESHOLD;

    // Predictor copy of the line stores, window and raster position
    class_t upper_cls [MAX_WIDTH];
    class_t mid_cls   [MAX_WIDTH];
    class_t win_cls   [9];
    int     col_cnt = 0;
    int     row_cnt = 0;

    edge_item_t edge_q [$];
    dir_row_t   dir_rows [DIR_ROWS];
    int         mismatch_count = 0;
    int         send_idle_pct  = 0;
    int         stall_pct      = 0;
    int         phase_items    = 0;

    hysteresis_edge_link_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Stall the result side at the current rate
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic int fold_size(input logic [SIZE_W-1:0] v, input int hi);
        int res;
        res = int'(v);
        if (res < 3)
            res = 3;
        else if (res > hi)
            res = hi;
        return res;
    endfunction

    // Advance the predictor by one pixel; returns 1 when an interior pixel is due
    function automatic logic link_pixel(input logic [MAG_W-1:0] mag,
                                        output edge_item_t res);
        int     w;
        int     h;
        int     c;
        int     r;
        class_t k;
        class_t up;
        class_t mid;
        logic   hit;
        w = fold_size(width_reg, MAX_WIDTH);
        h = fold_size(height_reg, MAX_HEIGHT);
        if (col_cnt >= w)
        begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h)
            row_cnt = 0;
        c = col_cnt;
        r = row_cnt;

        if (mag >= thr_high)
            k = CLS_STRONG;
        else if (mag >= thr_low)
            k = CLS_WEAK;
        else
            k = CLS_NONE;

        // Rotate the line stores at this column
        up = upper_cls[c];
        mid = mid_cls[c];
        upper_cls[c] = mid;
        mid_cls[c] = k;

        // Shift the window left and load the new column
        for (int i = 0; i < 3; i++)
        begin
            win_cls[i*3]   = win_cls[i*3+1];
            win_cls[i*3+1] = win_cls[i*3+2];
        end
        win_cls[2] = up;
        win_cls[5] = mid;
        win_cls[8] = k;

        hit = 1'b0;
        res = '0;
        if (c >= 2 && r >= 2)
        begin
            if (win_cls[4] == CLS_STRONG)
                res.is_edge = 1'b1;
            else if (win_cls[4] == CLS_WEAK)
                for (int i = 0; i < 9; i++)
                    if (i != 4 && win_cls[i] == CLS_STRONG)
                        res.is_edge = 1'b1;
            res.col = COORD_W'(c - 1);
            res.row = COORD_W'(r - 1);
            res.frame_last = (c == w - 1) && (r == h - 1);
            hit = 1'b1;
        end

        col_cnt = c + 1;
        if (col_cnt >= w)
        begin
            col_cnt = 0;
            row_cnt = r + 1;
            if (row_cnt >= h)
                row_cnt = 0;
        end
        return hit;
    endfunction

    // Magnitude near the current thresholds, mixing the strong, weak and none classes
    function automatic logic [MAG_W-1:0] pick_magnitude();
        int               sel;
        int               lim;
        logic [MAG_W-1:0] v;
        sel = $urandom_range(0, 9);
        lim = (thr_low < thr_high) ? int'(thr_low) : int'(thr_high);
        case (sel)
            0: v = MAG_W'($urandom);
            1: v = thr_high;
            2: v = thr_low;
            3, 4, 5:
                if (thr_low < thr_high)
                    v = MAG_W'($urandom_range(int'(thr_low), int'(thr_high) - 1));
                else
                    v = MAG_W'($urandom);
            6, 7:
                if (lim > 0)
                    v = MAG_W'($urandom_range(0, lim - 1));
                else
                    v = MAG_W'($urandom);
            default: v = MAG_W'($urandom_range(int'(thr_high), 65535));
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("ERROR %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Compare one accepted result with the oldest expectation
    task automatic check_result();
        edge_item_t want;
        if (edge_q.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing expected, tdata %h", m_tdata));
        end
        else
        begin
            want = edge_q.pop_front();
            if (m_tdata[0] !== want.is_edge)
                report_mismatch($sformatf("edge_res got %b want %b (col %0d row %0d)",
                                          m_tdata[0], want.is_edge, want.col, want.row));
            if (m_tdata[10:1] !== want.col)
                report_mismatch($sformatf("col got %0d want %0d", m_tdata[10:1], want.col));
            if (m_tdata[20:11] !== want.row)
                report_mismatch($sformatf("row got %0d want %0d", m_tdata[20:11], want.row));
            if (m_tdata[23:21] !== 3'b000)
                report_mismatch($sformatf("pad bits got %b", m_tdata[23:21]));
            if (m_tlast !== want.frame_last)
                report_mismatch($sformatf("frame_last got %b want %b (col %0d row %0d)",
                                          m_tlast, want.frame_last, want.col, want.row));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result();
    end

    task automatic set_idle_mode(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 57;
                stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                stall_pct = 57;
            end
            default:
            begin
                send_idle_pct = 37;
                stall_pct = 37;
            end
        endcase
    endtask

    // Drop the input stream, drain every expected result, then let the pipe settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (edge_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write one register; leaves cfg_valid high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_IMAGE_WIDTH:    width_reg  = data[SIZE_W-1:0];
            REG_IMAGE_HEIGHT:   height_reg = data[SIZE_W-1:0];
            REG_HIGH_THRESHOLD: thr_high   = data;
            REG_LOW_THRESHOLD:  thr_low    = data;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Offer one pixel, with random idle cycles ahead of it
    task automatic drive_pixel(input logic [MAG_W-1:0] mag, input logic typed,
                               input edge_item_t want);
        edge_item_t got;
        logic       hit;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= MAG_W'($urandom);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mag;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        hit = link_pixel(mag, got);
        if (typed)
            edge_q.push_back(want);
        else if (hit)
            edge_q.push_back(got);
        phase_items++;
        @(negedge clk);
    endtask

    task automatic apply_setting(input logic [CFG_DAT_W-1:0] w_data,
                                 input logic [CFG_DAT_W-1:0] h_data,
                                 input logic [THR_W-1:0] hi, input logic [THR_W-1:0] lo);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, w_data);
        write_reg(REG_IMAGE_HEIGHT, h_data);
        write_reg(REG_HIGH_THRESHOLD, hi);
        write_reg(REG_LOW_THRESHOLD, lo);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_frame();
        int n;
        n = fold_size(width_reg, MAX_WIDTH) * fold_size(height_reg, MAX_HEIGHT);
        for (int i = 0; i < n; i++)
            drive_pixel(pick_magnitude(), 1'b0, '0);
    endtask

    // Size data with random bits above the register width
    function automatic logic [CFG_DAT_W-1:0] size_word(input int v);
        return {5'($urandom), SIZE_W'(v)};
    endfunction

    task automatic load_directed();
        // 4x3 frame under reset thresholds: weak centre beside a strong corner at exactly
        // the high threshold, and a weak centre with only weak or none neighbours
        dir_rows[0]  = '{ROW_REG, REG_IMAGE_WIDTH,  16'd4, 1'b0, '0};
        dir_rows[1]  = '{ROW_REG, REG_IMAGE_HEIGHT, 16'd3, 1'b0, '0};
        dir_rows[2]  = '{ROW_PIX, REG_IMAGE_WIDTH, 16'd20000, 1'b0, '0};
        dir_rows[3]  = '{ROW_PIX, REG_IMAGE_WIDTH, 16'd0,     1'b0, '0};
        dir_rows[4]  = '{ROW_PIX, REG_IMAGE_WIDTH, 16'd0,     1'b0, '0};
        dir_rows[5]  = '{ROW_PIX, REG_IMAGE_WIDTH, 16'd0,     1'b0, '0};
        dir_rows[6]  = '{ROW_PIX, REG_IMAGE_WIDTH, 16'd0,     1'b0, '0};
        dir_rows[7]  = '{ROW_PIX, REG_IMAGE_WIDTH, 16'd8000,  1'b0, '0};
        dir_rows[8]  = '{ROW_PIX, REG_IMAGE_WIDTH, 16'd19999, 1'b0, '0};
        dir_rows[9]  = '{ROW_PIX, REG_IMAGE_WIDTH, 16'd0,     1'b0, '0};
        dir_rows[10] = '{ROW_PIX, REG_IMAGE_WIDTH, 16'd65535, 1'b0, '0};
        dir_rows[11] = '{ROW_PIX, REG_IMAGE_WIDTH, 16'd0,     1'b0, '0};
        dir_rows[12] = '{ROW_PIX, REG_IMAGE_WIDTH, 16'd0, 1'b1,
                         '{1'b1, 10'd1, 10'd1, 1'b0}};
        dir_rows[13] = '{ROW_PIX, REG_IMAGE_WIDTH, 16'd7999, 1'b1,
                         '{1'b0, 10'd2, 10'd1, 1'b1}};
        // Sizes below the minimum fold to 3x3; low threshold above high leaves no weak
        dir_rows[14] = '{ROW_REG, REG_IMAGE_WIDTH,    16'hF801, 1'b0, '0};
        dir_rows[15] = '{ROW_REG, REG_IMAGE_HEIGHT,   16'd0,    1'b0, '0};
        dir_rows[16] = '{ROW_REG, REG_HIGH_THRESHOLD, 16'd100,  1'b0, '0};
        dir_rows[17] = '{ROW_REG, REG_LOW_THRESHOLD,  16'd50000, 1'b0, '0};
        for (int i = 18; i < DIR_ROWS; i++)
            dir_rows[i] = '{ROW_PIX, REG_IMAGE_WIDTH, 16'd100, 1'b0, '0};
        dir_rows[22] = '{ROW_PIX, REG_IMAGE_WIDTH, 16'd99, 1'b0, '0};
        dir_rows[26] = '{ROW_PIX, REG_IMAGE_WIDTH, 16'd100, 1'b1,
                         '{1'b0, 10'd1, 10'd1, 1'b1}};
    endtask

    // Stimulus
    initial
    begin
        logic [CFG_DAT_W-1:0] w_data;
        logic [CFG_DAT_W-1:0] h_data;
        logic [THR_W-1:0]     hi;
        logic [THR_W-1:0]     lo;
        int                   a;
        int                   b;

        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            upper_cls[i] = CLS_NONE;
            mid_cls[i] = CLS_NONE;
        end
        for (int i = 0; i < 9; i++)
            win_cls[i] = CLS_NONE;
        load_directed();
        set_idle_mode(0);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].kind == ROW_REG)
            begin
                if (i == 0 || dir_rows[i-1].kind == ROW_PIX)
                    wait_idle();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end
            else
            begin
                cfg_valid <= 1'b0;
                drive_pixel(dir_rows[i].data[MAG_W-1:0], dir_rows[i].typed,
                            dir_rows[i].want);
            end
        end

        // Random frames, one setting and idle pattern per phase
        for (int p = 0; p < PHASES; p++)
        begin
            a = $urandom_range(0, 65535);
            b = $urandom_range(0, 65535);
            if ($urandom_range(0, 3) != 0)
            begin
                hi = THR_W'((a > b) ? a : b);
                lo = THR_W'((a > b) ? b : a);
            end
            else
            begin
                hi = THR_W'((a > b) ? b : a);
                lo = THR_W'((a > b) ? a : b);
            end
            w_data = size_word(($urandom_range(0, 6) == 0) ? $urandom_range(0, 2)
                                                            : $urandom_range(3, 12));
            h_data = size_word(($urandom_range(0, 6) == 0) ? $urandom_range(0, 2)
                                                            : $urandom_range(3, 7));
            case (p)
                1:
                begin
                    w_data = size_word(3);
                    h_data = size_word(3);
                end
                2:
                begin
                    w_data = size_word(2);
                    h_data = size_word(1);
                end
                3:
                begin
                    hi = '0;
                    lo = '0;
                end
                4:
                begin
                    hi = '1;
                    lo = '0;
                end
                5:
                begin
                    hi = '0;
                    lo = '1;
                end
                6:
                begin
                    hi = '1;
                    lo = '1;
                end
                7:
                begin
                    w_data = size_word(40);
                    h_data = size_word(3);
                end
                default: ;
            endcase
            apply_setting(w_data, h_data, hi, lo);
            set_idle_mode(p % 4);
            phase_items = 0;
            do
                run_frame();
            while (phase_items < PHASE_ITEMS);
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Guard against a hang
    initial
    begin
        #(LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/hel_pkg.sv
rtl/hel_ram.sv
rtl/hysteresis_edge_link_core.sv
sim/tb_top.sv
